>>> sv/bounded_double_ended_queue_defines.svh
// Assertion macros used by the port checker of the deque block.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BDEQ_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BDEQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bdeq_pkg.sv
`default_nettype none

package bdeq_pkg;

   localparam int DATA_W        = 32;
   localparam int CNT_W         = 11;
   localparam int DEFAULT_DEPTH = 1024;
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

   // front-to-back queue, power of two deep
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      REQ_INS_FRONT = 2'd0,
      REQ_INS_REAR  = 2'd1,
      REQ_REM_FRONT = 2'd2,
      REQ_REM_REAR  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_RESP
   } back_state_type;

   typedef struct packed {
      logic                     insert;
      logic                     at_front;
      logic signed [DATA_W-1:0] value;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_status_type;

endpackage

`default_nettype wire

>>> sv/bdeq_req_if.sv
`default_nettype none

interface bdeq_req_if import bdeq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

>>> sv/bdeq_rsp_if.sv
`default_nettype none

interface bdeq_rsp_if import bdeq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic signed [DATA_W-1:0] front_value;
   logic signed [DATA_W-1:0] rear_value;
   logic [CNT_W-1:0]         entry_count;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, output accepted, output front_value, output rear_value,
                   output entry_count, output is_empty, output is_full, input ready);
   modport sink (input valid, input accepted, input front_value, input rear_value,
                 input entry_count, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

>>> sv/bdeq_front.sv
`default_nettype none

module bdeq_front import bdeq_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   bdeq_req_if.sink        req_chan,
   input  wire logic       op_pop,
   output queue_status_type op_q
);

   op_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]  fill_ff, fill_in;
   logic                push;
   op_type              cls_op;
   req_code_type        code;

   assign req_chan.ready = (fill_ff != QFILL_W'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign op_q.valid     = (fill_ff != '0);
   assign op_q.op        = q_ff[rd_ptr_ff];

   // decode the request word
   always_comb begin
      code         = req_code_type'(req_chan.req_type);
      cls_op.value = req_chan.value;
      unique case (code)
         REQ_INS_FRONT: begin
            cls_op.insert   = 1'b1;
            cls_op.at_front = 1'b1;
         end
         REQ_INS_REAR: begin
            cls_op.insert   = 1'b1;
            cls_op.at_front = 1'b0;
         end
         REQ_REM_FRONT: begin
            cls_op.insert   = 1'b0;
            cls_op.at_front = 1'b1;
         end
         REQ_REM_REAR: begin
            cls_op.insert   = 1'b0;
            cls_op.at_front = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = op_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      unique case ({push, op_pop})
         2'b10:   fill_in = fill_ff + QFILL_W'(1);
         2'b01:   fill_in = fill_ff - QFILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls_op;
      end
   end

endmodule

`default_nettype wire

>>> sv/bdeq_back.sv
`default_nettype none

module bdeq_back import bdeq_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CNT_W-1:0] cap,
   input  wire queue_status_type op_q,
   output logic                  op_pop,
   bdeq_rsp_if.source            rsp_chan
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [DATA_W-1:0] mem [DEPTH];

   back_state_type    state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ok_ff, ok_in;
   logic [AW-1:0]     head_next, head_prev, tail_next, tail_prev;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] rd_front_ff, rd_rear_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_load;

   logic                     rsp_accepted_ff;
   logic signed [DATA_W-1:0] rsp_front_ff, rsp_rear_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic                     rsp_empty_ff, rsp_full_ff;

   assign head_next = (head_ff == LAST) ? '0 : head_ff + AW'(1);
   assign head_prev = (head_ff == '0) ? LAST : head_ff - AW'(1);
   assign tail_next = (tail_ff == LAST) ? '0 : tail_ff + AW'(1);
   assign tail_prev = (tail_ff == '0) ? LAST : tail_ff - AW'(1);

   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ok_in    = ok_ff;
      op_pop   = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (op_q.valid) begin
               op_pop   = 1'b1;
               state_in = S_READ;
               ok_in    = 1'b0;
               if (op_q.op.insert) begin
                  if (count_ff < cap) begin
                     ok_in    = 1'b1;
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     if (op_q.op.at_front) begin
                        head_in = head_prev;
                        wr_addr = head_prev;
                     end else begin
                        tail_in = tail_next;
                     end
                  end
               end else if (count_ff != '0) begin
                  ok_in    = 1'b1;
                  count_in = count_ff - CNT_W'(1);
                  if (op_q.op.at_front) begin
                     head_in = head_next;
                  end else begin
                     tail_in = tail_prev;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ring store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= op_q.op.value;
      end
      rd_front_ff <= mem[head_ff];
      rd_rear_ff  <= mem[tail_prev];
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_accepted_ff <= ok_ff;
         rsp_front_ff    <= (count_ff == '0) ? EMPTY_VALUE : rd_front_ff;
         rsp_rear_ff     <= (count_ff == '0) ? EMPTY_VALUE : rd_rear_ff;
         rsp_count_ff    <= count_ff;
         rsp_empty_ff    <= (count_ff == '0);
         rsp_full_ff     <= (count_ff >= cap);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.accepted    = rsp_accepted_ff;
   assign rsp_chan.front_value = rsp_front_ff;
   assign rsp_chan.rear_value  = rsp_rear_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;
   assign rsp_chan.is_full     = rsp_full_ff;

endmodule

`default_nettype wire

>>> sv/bounded_double_ended_queue.sv
// Bounded double-ended queue over a ring store of DEPTH 32-bit words.
// req_chan: valid/ready words of req_type (insert front, insert rear,
//   remove front, remove rear) and value. rsp_chan: one word per request
//   with accepted, front_value, rear_value (-1 when empty), entry_count,
//   is_empty and is_full. csr_wr_en/csr_wr_data write the capacity, which
//   is clamped to DEPTH; write it only while no request is in flight.
// Flow: a taken request passes the front queue and then the execute, store
//   read and response load steps of the back end sequencer, which starts
//   the next request only after the response load step.
// A 2-word queue in front lets requests be taken while the back end works
//   or while a response waits to be taken.
// Reset: empty deque, pointers at zero, capacity 1024; the store itself is
//   not cleared, since only held entries ever reach a response.
// Receiver stall: the response register holds its word; the back end then
//   waits, the front queue fills and req_chan.ready drops.
`default_nettype none

module bounded_double_ended_queue import bdeq_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CNT_W-1:0] csr_wr_data,
   bdeq_req_if.sink              req_chan,
   bdeq_rsp_if.source            rsp_chan
);

   localparam logic [CNT_W-1:0] DEPTH_CAP =
      (DEPTH >= 2 ** CNT_W) ? {CNT_W{1'b1}} : CNT_W'(DEPTH);

   logic [CNT_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] cap_eff;
   queue_status_type op_q;
   logic             op_pop;

   assign capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;
   assign cap_eff     = (capacity_ff > DEPTH_CAP) ? DEPTH_CAP : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   bdeq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .op_pop   (op_pop),
      .op_q     (op_q)
   );

   bdeq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cap      (cap_eff),
      .op_q     (op_q),
      .op_pop   (op_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

>>> sv/bdeq_checker.sv
`default_nettype none

`include "bounded_double_ended_queue_defines.svh"

module bdeq_port_checker import bdeq_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic                     rsp_accepted,
   input wire logic signed [DATA_W-1:0] rsp_front_value,
   input wire logic signed [DATA_W-1:0] rsp_rear_value,
   input wire logic [CNT_W-1:0]         rsp_entry_count,
   input wire logic                     rsp_is_empty,
   input wire logic                     rsp_is_full
);

   logic                       stall;
   logic [2*DATA_W+CNT_W:0]    word;
   logic                       empty_word;
   logic                       empty_ok;
   logic                       refused;
   logic                       refuse_ok;

   assign stall      = rsp_valid && !rsp_ready;
   assign word       = {rsp_accepted, rsp_front_value, rsp_rear_value, rsp_entry_count};
   assign empty_word = rsp_valid && rsp_is_empty;
   assign empty_ok   = (rsp_front_value == EMPTY_VALUE) && (rsp_rear_value == EMPTY_VALUE) &&
                       (rsp_entry_count == '0);
   assign refused    = rsp_valid && !rsp_accepted;
   assign refuse_ok  = rsp_is_full || rsp_is_empty;

   `BDEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, stall, rsp_valid && $stable(word), "word not held")
   `BDEQ_ASSERT_IMPL(a_empty_word, clock, reset, empty_word, empty_ok, "empty word carries data")
   `BDEQ_ASSERT_IMPL(a_refuse_cause, clock, reset, refused, refuse_ok, "refused without cause")
   `BDEQ_ASSERT_IMPL(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "valid after reset")

endmodule

bind bounded_double_ended_queue bdeq_port_checker u_bdeq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_accepted    (rsp_chan.accepted),
   .rsp_front_value (rsp_chan.front_value),
   .rsp_rear_value  (rsp_chan.rear_value),
   .rsp_entry_count (rsp_chan.entry_count),
   .rsp_is_empty    (rsp_chan.is_empty),
   .rsp_is_full     (rsp_chan.is_full)
);

`default_nettype wire
